[rtl/dvt_pkg.sv]
// shared types, codes and constants of the divider and reloading timer
package dvt_pkg;

	// request kinds
	typedef enum logic [1:0] {
		REQ_TICK  = 2'd0,
		REQ_READ  = 2'd1,
		REQ_WRITE = 2'd2,
		REQ_NONE  = 2'd3
	} req_kind_t;

	// register selects
	typedef enum logic [1:0] {
		SEL_DIV  = 2'd0,
		SEL_CNT  = 2'd1,
		SEL_MOD  = 2'd2,
		SEL_CTRL = 2'd3
	} reg_sel_t;

	// timer period selects in control bits 1:0
	typedef enum logic [1:0] {
		PER_1024 = 2'd0,
		PER_16   = 2'd1,
		PER_64   = 2'd2,
		PER_256  = 2'd3
	} period_sel_t;

	localparam int unsigned DataW  = 8;
	localparam int unsigned CountW = 12;
	localparam int unsigned EnBit  = 2;

	typedef logic [DataW-1:0]         byte_t;
	typedef logic signed [CountW-1:0] countdown_t;

	// controller states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_COUNT,
		ST_EMIT
	} ctrl_state_t;

	// controller to datapath
	typedef struct packed {
		logic accept;
		logic step;
		logic load_out;
	} dvt_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic step_due;
	} dvt_status_t;

	// reload period for the control select bits
	function automatic countdown_t period_for(input logic [1:0] sel);
		countdown_t p;
		unique case (period_sel_t'(sel))
			PER_1024: p = countdown_t'(1024);
			PER_16:   p = countdown_t'(16);
			PER_64:   p = countdown_t'(64);
			PER_256:  p = countdown_t'(256);
			default:  p = countdown_t'(1024);
		endcase
		return p;
	endfunction

endpackage

[rtl/dvt_req_if.sv]
// request channel: valid/ready with the request payload
interface dvt_req_if;
	logic             valid;
	logic             ready;
	logic [1:0]       req_type;
	logic [7:0]       cycles;
	logic [1:0]       reg_select;
	logic [7:0]       write_value;

	modport source (output valid, output req_type, output cycles, output reg_select,
		output write_value, input ready);
	modport sink (input valid, input req_type, input cycles, input reg_select,
		input write_value, output ready);
endinterface

[rtl/dvt_rsp_if.sv]
// response channel: valid/ready with the result payload
interface dvt_rsp_if;
	logic       valid;
	logic       ready;
	logic [7:0] read_data;
	logic       timer_irq;

	modport source (output valid, output read_data, output timer_irq, input ready);
	modport sink (input valid, input read_data, input timer_irq, output ready);
endinterface

[rtl/dvt_dp.sv]
// timer datapath: divider, counter registers, countdown and result registers
module dvt_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  dvt_pkg::dvt_cmd_t   cmd,
	output dvt_pkg::dvt_status_t status,
	input  logic [1:0]          req_type,
	input  logic [7:0]          cycles,
	input  logic [1:0]          reg_select,
	input  logic [7:0]          write_value,
	output logic [7:0]          read_data,
	output logic                timer_irq
);
	import dvt_pkg::*;

	byte_t      prescale_q;
	byte_t      div_q;
	byte_t      count_q;
	byte_t      modulo_q;
	byte_t      control_q;
	countdown_t countdown_q;
	logic       run_q;
	byte_t      rd_q;
	logic       irq_q;
	byte_t      out_data_q;
	logic       out_irq_q;

	logic [DataW:0] prescale_sum;
	byte_t          count_inc;
	byte_t          sel_data;
	logic           timer_en;

	// divider accumulation and read mux
	always_comb begin
		prescale_sum = {1'b0, prescale_q} + {1'b0, cycles};
		count_inc    = count_q + byte_t'(1);
		timer_en     = control_q[EnBit];
		unique case (reg_sel_t'(reg_select))
			SEL_DIV:  sel_data = div_q;
			SEL_CNT:  sel_data = count_q;
			SEL_MOD:  sel_data = modulo_q;
			SEL_CTRL: sel_data = control_q;
			default:  sel_data = control_q;
		endcase
	end

	// another reload is due while the countdown is zero or below during an enabled tick
	assign status.step_due = run_q && (countdown_q[CountW-1] || (countdown_q == '0));

	// architectural state and per-item result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prescale_q  <= '0;
			div_q       <= '0;
			count_q     <= '0;
			modulo_q    <= '0;
			control_q   <= '0;
			countdown_q <= '0;
			run_q       <= 1'b0;
			rd_q        <= '0;
			irq_q       <= 1'b0;
		end else if (cmd.accept) begin
			rd_q  <= '0;
			irq_q <= 1'b0;
			run_q <= 1'b0;
			unique case (req_kind_t'(req_type))
				REQ_TICK: begin
					prescale_q <= prescale_sum[DataW-1:0];
					div_q      <= div_q + byte_t'(prescale_sum[DataW]);
					if (timer_en) begin
						countdown_q <= countdown_q - countdown_t'({4'b0, cycles});
						run_q       <= 1'b1;
					end
				end
				REQ_READ: begin
					rd_q <= sel_data;
				end
				REQ_WRITE: begin
					unique case (reg_sel_t'(reg_select))
						SEL_DIV: begin
							div_q      <= '0;
							prescale_q <= '0;
						end
						SEL_CNT:  count_q   <= write_value;
						SEL_MOD:  modulo_q  <= write_value;
						SEL_CTRL: control_q <= write_value;
						default:  control_q <= write_value;
					endcase
				end
				default: begin
				end
			endcase
		end else if (cmd.step) begin
			// one reload per cycle; wrap reloads from modulo
			countdown_q <= countdown_q + period_for(control_q[1:0]);
			if (count_inc == '0) begin
				count_q <= modulo_q;
				irq_q   <= 1'b1;
			end else begin
				count_q <= count_inc;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_data_q <= '0;
			out_irq_q  <= 1'b0;
		end else if (cmd.load_out) begin
			out_data_q <= rd_q;
			out_irq_q  <= irq_q;
		end
	end

	assign read_data = out_data_q;
	assign timer_irq = out_irq_q;

endmodule

[rtl/dvt_ctrl.sv]
// timer controller: sequences accept, reload steps and result hand-off
module dvt_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	input  logic [1:0]           req_type,
	output logic                 req_ready,
	output logic                 rsp_valid,
	input  logic                 rsp_ready,
	input  dvt_pkg::dvt_status_t status,
	output dvt_pkg::dvt_cmd_t    cmd
);
	import dvt_pkg::*;

	ctrl_state_t state_q;
	ctrl_state_t state_next;
	logic        out_valid_q;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	// next state and commands
	always_comb begin
		state_next   = state_q;
		req_ready    = 1'b0;
		cmd.accept   = 1'b0;
		cmd.step     = 1'b0;
		cmd.load_out = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				req_ready  = 1'b1;
				cmd.accept = req_valid;
				if (req_valid) begin
					state_next = (req_kind_t'(req_type) == REQ_TICK) ? ST_COUNT : ST_EMIT;
				end
			end
			ST_COUNT: begin
				if (status.step_due) begin
					cmd.step = 1'b1;
				end else begin
					state_next = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (!out_valid_q || rsp_ready) begin
					cmd.load_out = 1'b1;
					state_next   = ST_IDLE;
				end
			end
			default: state_next = ST_IDLE;
		endcase
	end

	// output valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign rsp_valid = out_valid_q;

endmodule

[rtl/divider_and_reloading_timer.sv]
// top level of the divider and reloading timer
// Timer with a free-running divider and a reloading counter. Each request
// transfer is a tick, a register read or a register write and yields exactly
// one response transfer. Reads, writes and requests of the unused kind pass
// from the idle state to the emit state, which loads the output register. A
// tick first passes through the count state for its n countdown reloads:
// zero with the timer disabled, at most 16 with cycles at 255 on the period
// select of 16. A single reload adder performs one reload per cycle. The
// request port opens again in the cycle after the response is loaded. A new
// request is taken once the previous result sits in the output register,
// even if it has not yet been transferred. A stalled response holds the next
// result in the datapath result registers while the controller waits in the
// emit state until the output register frees up.
module divider_and_reloading_timer (
	input logic clk,
	input logic arst_n,
	dvt_req_if.sink   req,
	dvt_rsp_if.source rsp
);
	import dvt_pkg::*;

	dvt_cmd_t    cmd;
	dvt_status_t status;

	dvt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_type  (req.req_type),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.status    (status),
		.cmd       (cmd)
	);

	dvt_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.status      (status),
		.req_type    (req.req_type),
		.cycles      (req.cycles),
		.reg_select  (req.reg_select),
		.write_value (req.write_value),
		.read_data   (rsp.read_data),
		.timer_irq   (rsp.timer_irq)
	);

	// no reload step while a request is being taken
	a_step_no_accept: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step |-> !req.ready)
		else $error("reload step while request port open");

	// accepting a request and loading a result never coincide
	a_accept_no_load: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |-> !cmd.load_out)
		else $error("accept and result load in the same cycle");

	// a loaded result is presented next cycle
	a_load_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |=> rsp.valid)
		else $error("loaded result not presented");

	// a new response only appears after a result load
	a_rise_from_load: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp.valid) |-> $past(cmd.load_out))
		else $error("response valid without result load");

endmodule

[bench/divider_and_reloading_timer_test.sv]
// testbench of the divider and reloading timer: directed table then random requests
`timescale 1ns / 100ps

module divider_and_reloading_timer_test;
	import dvt_pkg::*;

	localparam int DivStep      = 256;
	localparam int NumDirected  = 26;
	localparam int NumRandom    = 850;
	localparam int HoldAfter    = 250;
	localparam int HoldCycles   = 400;
	localparam int DrainAt      = 600;
	localparam int SettleCycles = 24;

	typedef struct packed {
		byte_t read_data;
		logic  timer_irq;
	} timer_rsp_t;

	typedef struct packed {
		req_kind_t kind;
		byte_t     cycles;
		reg_sel_t  sel;
		byte_t     value;
		logic      fixed;
		byte_t     exp_rd;
		logic      exp_irq;
	} req_row_t;

	logic clk;
	logic arst_n;

	dvt_req_if req_ch();
	dvt_rsp_if rsp_ch();

	divider_and_reloading_timer u_top (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch)
	);

	// timer state as the predictor sees it
	byte_t m_prescale = '0;
	byte_t m_div      = '0;
	byte_t m_count    = '0;
	byte_t m_reload_byte = '0;
	byte_t m_ctrl_byte   = '0;
	int    m_countdown = 0;

	timer_rsp_t awaited_responses[$];

	int  mismatches   = 0;
	int  results_seen = 0;
	int  irq_results  = 0;
	int  n_ticks      = 0;
	int  n_reads      = 0;
	int  n_writes     = 0;
	int  n_unused     = 0;
	bit  calm         = 1'b0;

	// directed rows: fixed ones carry the response typed in, the rest use the predictor
	req_row_t directed_rows [NumDirected] = '{
		'{REQ_READ,  8'd0,   SEL_DIV,  8'h00, 1'b1, 8'h00, 1'b0},
		'{REQ_READ,  8'd0,   SEL_CNT,  8'h00, 1'b1, 8'h00, 1'b0},
		'{REQ_READ,  8'd0,   SEL_CTRL, 8'h00, 1'b1, 8'h00, 1'b0},
		'{REQ_TICK,  8'd255, SEL_DIV,  8'h00, 1'b1, 8'h00, 1'b0},
		'{REQ_TICK,  8'd1,   SEL_DIV,  8'h00, 1'b1, 8'h00, 1'b0},
		'{REQ_READ,  8'd0,   SEL_DIV,  8'h00, 1'b1, 8'h01, 1'b0},
		'{REQ_WRITE, 8'd0,   SEL_DIV,  8'hA5, 1'b1, 8'h00, 1'b0},
		'{REQ_READ,  8'd0,   SEL_DIV,  8'h00, 1'b1, 8'h00, 1'b0},
		'{REQ_WRITE, 8'd0,   SEL_MOD,  8'hFF, 1'b1, 8'h00, 1'b0},
		'{REQ_WRITE, 8'd0,   SEL_CNT,  8'hFE, 1'b1, 8'h00, 1'b0},
		'{REQ_WRITE, 8'd0,   SEL_CTRL, 8'hFD, 1'b1, 8'h00, 1'b0},
		'{REQ_READ,  8'd0,   SEL_CTRL, 8'h00, 1'b1, 8'hFD, 1'b0},
		'{REQ_TICK,  8'd0,   SEL_DIV,  8'h00, 1'b0, 8'h00, 1'b0},
		'{REQ_TICK,  8'd255, SEL_DIV,  8'h00, 1'b0, 8'h00, 1'b0},
		'{REQ_READ,  8'd0,   SEL_CNT,  8'h00, 1'b0, 8'h00, 1'b0},
		'{REQ_WRITE, 8'd0,   SEL_CTRL, 8'h04, 1'b1, 8'h00, 1'b0},
		'{REQ_TICK,  8'd200, SEL_DIV,  8'h00, 1'b0, 8'h00, 1'b0},
		'{REQ_TICK,  8'd255, SEL_DIV,  8'h00, 1'b0, 8'h00, 1'b0},
		'{REQ_WRITE, 8'd0,   SEL_CTRL, 8'h07, 1'b1, 8'h00, 1'b0},
		'{REQ_TICK,  8'd128, SEL_DIV,  8'h00, 1'b0, 8'h00, 1'b0},
		'{REQ_WRITE, 8'd0,   SEL_CTRL, 8'h06, 1'b1, 8'h00, 1'b0},
		'{REQ_TICK,  8'd255, SEL_DIV,  8'h00, 1'b0, 8'h00, 1'b0},
		'{REQ_WRITE, 8'd0,   SEL_CTRL, 8'hFB, 1'b1, 8'h00, 1'b0},
		'{REQ_TICK,  8'd100, SEL_DIV,  8'h00, 1'b0, 8'h00, 1'b0},
		'{REQ_NONE,  8'd255, SEL_CTRL, 8'hFF, 1'b1, 8'h00, 1'b0},
		'{REQ_READ,  8'd0,   SEL_MOD,  8'h00, 1'b1, 8'hFF, 1'b0}
	};

	// advance the predicted timer by one request and return its response
	function automatic timer_rsp_t apply_request(input req_kind_t kind, input byte_t cyc,
		input reg_sel_t sel, input byte_t value);
		timer_rsp_t r;
		int acc;
		r = '0;
		case (kind)
			REQ_TICK: begin
				// divider steps once per 256 accumulated cycles
				acc = int'(m_prescale) + int'(cyc);
				m_div = m_div + byte_t'(acc / DivStep);
				m_prescale = byte_t'(acc % DivStep);
				// countdown only runs with the enable bit set
				if (m_ctrl_byte[EnBit]) begin
					m_countdown = m_countdown - int'(cyc);
					while (m_countdown <= 0) begin
						case (period_sel_t'(m_ctrl_byte[1:0]))
							PER_16:  m_countdown = m_countdown + 16;
							PER_64:  m_countdown = m_countdown + 64;
							PER_256: m_countdown = m_countdown + 256;
							default: m_countdown = m_countdown + 1024;
						endcase
						m_count = m_count + 8'd1;
						if (m_count == 8'd0) begin
							m_count = m_reload_byte;
							r.timer_irq = 1'b1;
						end
					end
				end
			end
			REQ_READ: begin
				case (sel)
					SEL_DIV: r.read_data = m_div;
					SEL_CNT: r.read_data = m_count;
					SEL_MOD: r.read_data = m_reload_byte;
					default: r.read_data = m_ctrl_byte;
				endcase
			end
			REQ_WRITE: begin
				case (sel)
					SEL_DIV: begin
						m_div = '0;
						m_prescale = '0;
					end
					SEL_CNT: m_count = value;
					SEL_MOD: m_reload_byte = value;
					default: m_ctrl_byte = value;
				endcase
			end
			default: r = '0;
		endcase
		return r;
	endfunction

	// mostly short idle stretches, now and then a long one
	function automatic int idle_length();
		if ($urandom_range(0, 99) < 85)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// random request, weighted toward ticks and enabled timer settings
	function automatic req_row_t random_request();
		req_row_t r;
		int p;
		r = '0;
		r.cycles = byte_t'($urandom_range(0, 255));
		r.sel = reg_sel_t'($urandom_range(0, 3));
		r.value = byte_t'($urandom_range(0, 255));
		p = $urandom_range(0, 99);
		if (p < 45) begin
			r.kind = REQ_TICK;
			p = $urandom_range(0, 9);
			if (p < 2)
				r.cycles = 8'hFF;
			else if (p < 4)
				r.cycles = byte_t'($urandom_range(0, 20));
		end else if (p < 70) begin
			r.kind = REQ_READ;
		end else if (p < 95) begin
			r.kind = REQ_WRITE;
			if (r.sel == SEL_CTRL && $urandom_range(0, 3) != 0)
				r.value[EnBit] = 1'b1;
			if (r.sel == SEL_CNT && $urandom_range(0, 1) == 1)
				r.value[7:4] = 4'hF;
		end else begin
			r.kind = REQ_NONE;
		end
		return r;
	endfunction

	// clock
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// request side: reset, directed table, random requests, then drain
	initial begin
		req_row_t row;
		timer_rsp_t resp;
		int gap;
		arst_n <= 1'b0;
		req_ch.valid <= 1'b0;
		req_ch.req_type <= REQ_NONE;
		req_ch.cycles <= '0;
		req_ch.reg_select <= SEL_DIV;
		req_ch.write_value <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int i = 0; i < NumDirected + NumRandom; i++) begin
			if (i < NumDirected)
				row = directed_rows[i];
			else
				row = random_request();
			if (i % 64 == 0)
				calm = ($urandom_range(0, 3) == 0);
			// pause until every response has come back
			if (i == DrainAt) begin
				req_ch.valid <= 1'b0;
				do @(posedge clk); while (awaited_responses.size() != 0);
			end
			gap = (calm || $urandom_range(0, 1) == 0) ? 0 : idle_length();
			if (gap > 0) begin
				req_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			req_ch.valid <= 1'b1;
			req_ch.req_type <= row.kind;
			req_ch.cycles <= row.cycles;
			req_ch.reg_select <= row.sel;
			req_ch.write_value <= row.value;
			do @(posedge clk); while (!req_ch.ready);
			// transfer taken: predict its response
			resp = apply_request(row.kind, row.cycles, row.sel, row.value);
			if (row.fixed)
				resp = '{read_data: row.exp_rd, timer_irq: row.exp_irq};
			awaited_responses.push_back(resp);
			case (row.kind)
				REQ_TICK:  n_ticks++;
				REQ_READ:  n_reads++;
				REQ_WRITE: n_writes++;
				default:   n_unused++;
			endcase
		end
		req_ch.valid <= 1'b0;
		while (awaited_responses.size() != 0) @(posedge clk);
		repeat (SettleCycles) @(posedge clk);
		$display("covered %0d requests: %0d ticks, %0d reads, %0d writes, %0d unused kind",
			n_ticks + n_reads + n_writes + n_unused, n_ticks, n_reads, n_writes, n_unused);
		$display("%0d responses compared, %0d of them with the interrupt raised",
			results_seen, irq_results);
		if (mismatches == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

	// response side: compare each transfer, then pick ready for the next cycle
	initial begin
		int stall_left;
		bit long_hold_done;
		timer_rsp_t want;
		stall_left = 0;
		long_hold_done = 1'b0;
		rsp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (rsp_ch.valid && rsp_ch.ready) begin
				results_seen++;
				if (rsp_ch.timer_irq === 1'b1)
					irq_results++;
				if (awaited_responses.size() == 0) begin
					mismatches++;
					$display("%0t: response with none expected, read_data %02h timer_irq %0b",
						$time, rsp_ch.read_data, rsp_ch.timer_irq);
				end else begin
					want = awaited_responses.pop_front();
					if (rsp_ch.read_data !== want.read_data) begin
						mismatches++;
						$display("%0t: read_data expected %02h got %02h",
							$time, want.read_data, rsp_ch.read_data);
					end
					if (rsp_ch.timer_irq !== want.timer_irq) begin
						mismatches++;
						$display("%0t: timer_irq expected %0b got %0b",
							$time, want.timer_irq, rsp_ch.timer_irq);
					end
				end
			end
			// one long hold-off so the block backs up into the request side
			if (!long_hold_done && results_seen >= HoldAfter) begin
				long_hold_done = 1'b1;
				stall_left = HoldCycles;
			end else if (stall_left == 0 && !calm && $urandom_range(0, 3) == 0) begin
				stall_left = idle_length();
			end
			if (stall_left > 0) begin
				rsp_ch.ready <= 1'b0;
				stall_left--;
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	// run limit
	initial begin
		#15_000_000;
		$display("%0t: run limit reached, %0d responses outstanding",
			$time, awaited_responses.size());
		$display("CHECK FAILED");
		$finish;
	end

endmodule
